// ===== hdl/fbsa_pkg.sv =====
// shared types, constants and helpers for the framebuffer sram arbiter
// no dependencies

package fbsa_pkg;

    localparam int WORD_ADDR_BITS = 15;
    localparam int BYTE_ADDR_BITS = WORD_ADDR_BITS + 2;

    localparam logic [3:0] ENABLES_NONE_N = 4'hF;
    localparam logic [3:0] ENABLES_LANE3_N = 4'h7;
    localparam logic [3:0] ENABLES_LANE2_N = 4'hB;
    localparam logic [3:0] ENABLES_LANE1_N = 4'hD;
    localparam logic [3:0] ENABLES_LANE0_N = 4'hE;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LOW     = 3'd1,
        PH_HIGH    = 3'd2,
        PH_CAPTURE = 3'd3,
        PH_HOLD    = 3'd4
    } phase_t;

    typedef struct packed {
        logic                      lcd_request;
        logic [BYTE_ADDR_BITS-1:0] lcd_byte_address;
        logic                      host_request;
        logic                      host_write;
        logic [BYTE_ADDR_BITS-1:0] host_byte_address;
        logic [7:0]                host_write_byte;
        logic [31:0]               ram_read_data;
    } fbsa_in_t;

    typedef struct packed {
        logic                      ram_clock;
        logic [WORD_ADDR_BITS-1:0] ram_word_address;
        logic [3:0]                ram_write_enable_n;
        logic [31:0]               ram_write_data;
        logic [31:0]               lcd_read_data;
        logic                      lcd_done;
        logic [7:0]                host_read_data;
        logic                      host_done;
    } fbsa_out_t;

    // byte offset k drives lane 3-k low
    function automatic logic [3:0] lane_enables_n(input logic [1:0] offset);
        logic [3:0] en_n;
        case (offset)
            2'd0:    en_n = ENABLES_LANE3_N;
            2'd1:    en_n = ENABLES_LANE2_N;
            2'd2:    en_n = ENABLES_LANE1_N;
            2'd3:    en_n = ENABLES_LANE0_N;
            default: en_n = ENABLES_NONE_N;
        endcase
        return en_n;
    endfunction

    // byte offset k reads lane 3-k, offset zero is the top byte
    function automatic logic [7:0] lane_byte(input logic [31:0] word,
                                             input logic [1:0]  offset);
        logic [7:0] b;
        case (offset)
            2'd0:    b = word[31:24];
            2'd1:    b = word[23:16];
            2'd2:    b = word[15:8];
            2'd3:    b = word[7:0];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/framebuffer_sram_arbiter.sv =====
// an accepted item goes through the input register and then the result register
// throughput: one item per cycle while not stalled, a new item may be accepted while a result waits
// the sequencer step runs once per item between the input and result registers
// reset: asynchronous active low, sequencer idle, display rearmed, enables all high
// depends on fbsa_pkg

module framebuffer_sram_arbiter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_valid,
    output logic               tick_ready,
    input  fbsa_pkg::fbsa_in_t tick,
    output logic               result_valid,
    input  logic               result_ready,
    output fbsa_pkg::fbsa_out_t result
);

    // input register
    logic                tick_valid_reg;
    fbsa_pkg::fbsa_in_t  tick_reg;

    // sequencer state
    fbsa_pkg::phase_t                    phase_reg;
    fbsa_pkg::phase_t                    phase_next;
    logic                                serving_display_reg;
    logic                                serving_display_next;
    logic                                access_is_write_reg;
    logic                                access_is_write_next;
    logic                                display_rearmed_reg;
    logic                                display_rearmed_next;
    logic [1:0]                          byte_lane_reg;
    logic [1:0]                          byte_lane_next;
    logic [fbsa_pkg::WORD_ADDR_BITS-1:0] word_address_reg;
    logic [fbsa_pkg::WORD_ADDR_BITS-1:0] word_address_next;
    logic [7:0]                          write_byte_reg;
    logic [7:0]                          write_byte_next;
    logic [3:0]                          enables_n_reg;
    logic [3:0]                          enables_n_next;
    logic [31:0]                         display_word_reg;
    logic [31:0]                         display_word_next;
    logic [7:0]                          host_byte_reg;
    logic [7:0]                          host_byte_next;

    // result register
    logic                 result_valid_reg;
    fbsa_pkg::fbsa_out_t  result_reg;
    fbsa_pkg::fbsa_out_t  result_next;

    logic step;
    logic grant_display;
    logic grant_host;
    logic rearm;

    // the sequencer advances whenever the item in the input register can be
    // moved into a free (or freeing) result register
    assign step       = tick_valid_reg && (!result_valid_reg || result_ready);
    assign tick_ready = !tick_valid_reg || step;

    // display already rearmed, or its request dropped this tick, so the display may be granted again
    assign rearm         = display_rearmed_reg || !tick_reg.lcd_request;
    assign grant_display = tick_reg.lcd_request && rearm;
    assign grant_host    = !grant_display && tick_reg.host_request;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (tick_ready)
        begin
            tick_valid_reg <= tick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            tick_reg <= tick;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                fbsa_pkg::PH_LOW:
                begin
                    phase_next = fbsa_pkg::PH_HIGH;
                end
                fbsa_pkg::PH_HIGH:
                begin
                    phase_next = fbsa_pkg::PH_CAPTURE;
                end
                fbsa_pkg::PH_CAPTURE:
                begin
                    phase_next = serving_display_reg ? fbsa_pkg::PH_IDLE
                                                     : fbsa_pkg::PH_HOLD;
                end
                fbsa_pkg::PH_HOLD:
                begin
                    phase_next = fbsa_pkg::PH_IDLE;
                end
                default:
                begin
                    // idle, and any unused code behaves as idle
                    phase_next = (grant_display || grant_host) ? fbsa_pkg::PH_LOW
                                                               : fbsa_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // latched access data and the result item
    always_comb
    begin
        serving_display_next = serving_display_reg;
        access_is_write_next = access_is_write_reg;
        display_rearmed_next = display_rearmed_reg;
        byte_lane_next       = byte_lane_reg;
        word_address_next    = word_address_reg;
        write_byte_next      = write_byte_reg;
        enables_n_next       = enables_n_reg;
        display_word_next    = display_word_reg;
        host_byte_next       = host_byte_reg;
        result_next          = result_reg;

        if (step)
        begin
            display_rearmed_next = rearm;
            result_next.ram_clock = 1'b1;
            result_next.lcd_done  = 1'b0;
            result_next.host_done = 1'b0;

            case (phase_reg)
                fbsa_pkg::PH_LOW:
                begin
                    // setup half of the sram clock, enables go out here
                    result_next.ram_clock = 1'b0;
                    enables_n_next = access_is_write_reg
                                   ? fbsa_pkg::lane_enables_n(byte_lane_reg)
                                   : fbsa_pkg::ENABLES_NONE_N;
                end
                fbsa_pkg::PH_HIGH:
                begin
                end
                fbsa_pkg::PH_CAPTURE:
                begin
                    if (serving_display_reg)
                    begin
                        display_word_next     = tick_reg.ram_read_data;
                        result_next.lcd_done  = 1'b1;
                        display_rearmed_next  = 1'b0;
                    end
                    else
                    begin
                        // a host write captures the read port too
                        host_byte_next = fbsa_pkg::lane_byte(tick_reg.ram_read_data,
                                                             byte_lane_reg);
                        result_next.host_done = 1'b1;
                    end
                end
                fbsa_pkg::PH_HOLD:
                begin
                    result_next.host_done = 1'b1;
                end
                default:
                begin
                    if (grant_display)
                    begin
                        serving_display_next = 1'b1;
                        access_is_write_next = 1'b0;
                        word_address_next    =
                            tick_reg.lcd_byte_address[fbsa_pkg::BYTE_ADDR_BITS-1:2];
                    end
                    else if (grant_host)
                    begin
                        serving_display_next = 1'b0;
                        access_is_write_next = tick_reg.host_write;
                        word_address_next    =
                            tick_reg.host_byte_address[fbsa_pkg::BYTE_ADDR_BITS-1:2];
                        byte_lane_next       = tick_reg.host_byte_address[1:0];
                        write_byte_next      = tick_reg.host_write_byte;
                    end
                end
            endcase

            // result shows the state after this tick
            result_next.ram_word_address   = word_address_next;
            result_next.ram_write_enable_n = enables_n_next;
            result_next.ram_write_data     = {4{write_byte_next}};
            result_next.lcd_read_data      = display_word_next;
            result_next.host_read_data     = host_byte_next;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= fbsa_pkg::PH_IDLE;
            serving_display_reg <= 1'b0;
            access_is_write_reg <= 1'b0;
            display_rearmed_reg <= 1'b1;
            byte_lane_reg       <= 2'd0;
            word_address_reg    <= '0;
            write_byte_reg      <= 8'd0;
            enables_n_reg       <= fbsa_pkg::ENABLES_NONE_N;
            display_word_reg    <= 32'd0;
            host_byte_reg       <= 8'd0;
        end
        else
        begin
            phase_reg           <= phase_next;
            serving_display_reg <= serving_display_next;
            access_is_write_reg <= access_is_write_next;
            display_rearmed_reg <= display_rearmed_next;
            byte_lane_reg       <= byte_lane_next;
            word_address_reg    <= word_address_next;
            write_byte_reg      <= write_byte_next;
            enables_n_reg       <= enables_n_next;
            display_word_reg    <= display_word_next;
            host_byte_reg       <= host_byte_next;
        end
    end

    // result register, freed by the downstream ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/fbsa_checker.sv =====
// port-level checks for the framebuffer sram arbiter, with its bind
// depends on fbsa_pkg and framebuffer_sram_arbiter

module fbsa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                tick_ready,
    input logic                result_valid,
    input logic                result_ready,
    input fbsa_pkg::fbsa_out_t result
);

    logic result_take;
    logic last_clock_low_reg;

    assign result_take = result_valid && result_ready;

    // clock level of the last delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_clock_low_reg <= 1'b0;
        end
        else if (result_take)
        begin
            last_clock_low_reg <= !result.ram_clock;
        end
    end

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // only one port completes in an item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.lcd_done && result.host_done))
        else $error("both ports done together");

    // enables are none or a single lane
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.ram_write_enable_n == fbsa_pkg::ENABLES_NONE_N ||
                          result.ram_write_enable_n == fbsa_pkg::ENABLES_LANE3_N ||
                          result.ram_write_enable_n == fbsa_pkg::ENABLES_LANE2_N ||
                          result.ram_write_enable_n == fbsa_pkg::ENABLES_LANE1_N ||
                          result.ram_write_enable_n == fbsa_pkg::ENABLES_LANE0_N))
        else $error("bad lane enables");

    // the clock low phase never repeats and never coincides with a completion
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.ram_clock |->
            !last_clock_low_reg && !result.lcd_done && !result.host_done)
        else $error("clock low phase misplaced");

    // the input side is never stalled while the output is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> tick_ready)
        else $error("input stalled with empty output");

endmodule

bind framebuffer_sram_arbiter fbsa_checker u_fbsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_ready   (tick_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
